// File: rtl/core/qdpa_pkg.sv
package qdpa_pkg;

  // Phase positions along the pin sequence 11, 10, 00, 01
  localparam logic [2:0] POS_WRAP_LO = 3'd0;  // alias of POS_01 below position 1
  localparam logic [2:0] POS_11      = 3'd1;
  localparam logic [2:0] POS_10      = 3'd2;
  localparam logic [2:0] POS_00      = 3'd3;
  localparam logic [2:0] POS_01      = 3'd4;
  localparam logic [2:0] POS_WRAP_HI = 3'd5;  // alias of POS_11 above position 4

  // Pin patterns
  localparam logic [1:0] PINS_00 = 2'b00;
  localparam logic [1:0] PINS_01 = 2'b01;
  localparam logic [1:0] PINS_10 = 2'b10;
  localparam logic [1:0] PINS_11 = 2'b11;

  // Command codes carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_INIT   = 1'b1;

  // Gap recorded when it does not fit in 16 bits
  localparam logic [15:0] GAP_OVERFLOW = 16'h0000;

  localparam int GAP_W   = 16;
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;

  // Expected pins at each phase position, including the two wrap aliases
  function automatic logic [1:0] pins_at(input logic [2:0] pos);
    logic [1:0] p;
    case (pos)
      POS_WRAP_LO: p = PINS_01;
      POS_11:      p = PINS_11;
      POS_10:      p = PINS_10;
      POS_00:      p = PINS_00;
      POS_01:      p = PINS_01;
      POS_WRAP_HI: p = PINS_11;
      default:     p = PINS_01;
    endcase
    return p;
  endfunction

  // Phase position for an init command
  function automatic logic [2:0] pos_of(input logic [1:0] pins);
    logic [2:0] pos;
    case (pins)
      PINS_11: pos = POS_11;
      PINS_10: pos = POS_10;
      PINS_00: pos = POS_00;
      default: pos = POS_01;
    endcase
    return pos;
  endfunction

endpackage

// File: rtl/core/qdpa_ram.sv
module qdpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/quadrature_decoder_with_period_average.sv
// Quadrature decoder with a running average of cycle times. Each input
// transaction carries the two encoder pins and a 32-bit microsecond timestamp;
// tuser selects a pin sample (0) or an init command (1) that loads the phase
// and the reference time. One result transaction comes back per input: the
// step error flag, the signed 16-bit cycle count and the ring total divided
// by SAMPLES. The block accepts one transaction every clock unless m_tready
// is low while both stages hold data. Stage A registers the state update;
// stage B registers the reciprocal multiply for the average and sets
// m_tvalid. The gap ring lives in a RAM with a registered read that is
// addressed with the next ring index, so no clearing pass is needed after
// reset: a fill flag makes unwritten entries read as zero.
module quadrature_decoder_with_period_average
  import qdpa_pkg::*;
#(
  parameter int SAMPLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] pins, [33:2] time_us, [39:34] zero
  input  logic        s_tuser,   // [0] cmd
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] position_count, [31:16] average_step_time
  output logic        m_tuser    // [0] step_error
);

  localparam int IDX_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int TOT_W   = GAP_W + IDX_W;
  localparam int SH      = TOT_W + IDX_W;
  localparam int RECIP_W = TOT_W + 2;
  localparam int PROD_W  = TOT_W + RECIP_W;
  // ceil(2^SH / SAMPLES): exact floor division for any TOT_W-bit total
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

  // Input fields
  logic              cmd;
  logic [1:0]        pins;
  logic [TIME_W-1:0] time_us;

  assign cmd     = s_tuser;
  assign pins    = s_tdata[1:0];
  assign time_us = s_tdata[33:2];

  // State
  logic [2:0]         phase;
  logic [2:0]         phase_next;
  logic [TIME_W-1:0]  prev_time;
  logic [TIME_W-1:0]  prev_time_next;
  logic [COUNT_W-1:0] cycle_count;
  logic [COUNT_W-1:0] cycle_count_next;
  logic [IDX_W-1:0]   ring_index;
  logic [IDX_W-1:0]   ring_index_next;
  logic [TOT_W-1:0]   gap_total;
  logic [TOT_W-1:0]   gap_total_next;
  logic               full;
  logic               full_next;

  // Pipeline control
  logic a_valid;
  logic a_err;
  logic b_load;
  logic s_fire;

  // Ring RAM and read bypass
  logic [GAP_W-1:0] ram_rdata;
  logic [GAP_W-1:0] byp_data;
  logic             byp;
  logic             record;
  logic [GAP_W-1:0] entry;
  logic [GAP_W-1:0] old_entry;

  // Decode
  logic [2:0]        pos;
  logic              fwd;
  logic              back;
  logic              same;
  logic              step_err;
  logic [TIME_W-1:0] gap;

  assign b_load   = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || b_load;
  assign s_fire   = s_tvalid && s_tready;

  // Phase tracking and step classification
  always_comb begin
    pos  = (phase < POS_11 || phase > POS_01) ? POS_01 : phase;
    fwd  = (pins == pins_at(pos + 3'd1));
    back = !fwd && (pins == pins_at(pos - 3'd1));
    same = (pins == pins_at(pos));
    step_err = (cmd == CMD_SAMPLE) && !fwd && !back && !same;
    gap   = time_us - prev_time;
    entry = (gap[TIME_W-1:GAP_W] == '0) ? gap[GAP_W-1:0] : GAP_OVERFLOW;
    old_entry = full ? (byp ? byp_data : ram_rdata) : '0;
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    prev_time_next   = prev_time;
    cycle_count_next = cycle_count;
    record           = 1'b0;
    if (s_fire) begin
      if (cmd == CMD_INIT) begin
        phase_next     = pos_of(pins);
        prev_time_next = time_us;
      end else if (fwd) begin
        prev_time_next = time_us;
        if (pos == POS_01) begin
          phase_next       = POS_11;
          cycle_count_next = cycle_count + COUNT_W'(1);
          record           = 1'b1;
        end else begin
          phase_next = pos + 3'd1;
        end
      end else if (back) begin
        prev_time_next = time_us;
        phase_next     = (pos == POS_11) ? POS_01 : pos - 3'd1;
        if (pos == POS_10) begin
          cycle_count_next = cycle_count - COUNT_W'(1);
          record           = 1'b1;
        end
      end else if (same) begin
        prev_time_next = time_us;
      end
    end
    ring_index_next = ring_index;
    gap_total_next  = gap_total;
    full_next       = full;
    if (record) begin
      ring_index_next = (ring_index == IDX_LAST) ? '0 : ring_index + IDX_W'(1);
      gap_total_next  = gap_total - TOT_W'(old_entry) + TOT_W'(entry);
      if (ring_index == IDX_LAST) begin
        full_next = 1'b1;
      end
    end
  end

  // Gap ring storage, read address is the next ring index
  qdpa_ram #(
    .WIDTH (GAP_W),
    .DEPTH (SAMPLES)
  ) u_ring (
    .clk   (clk),
    .we    (record),
    .waddr (ring_index),
    .wdata (entry),
    .raddr (ring_index_next),
    .rdata (ram_rdata)
  );

  // Write-to-read bypass for the same entry
  always_ff @(posedge clk) begin
    byp_data <= entry;
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= record && (ring_index == ring_index_next);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= POS_01;
      prev_time   <= '0;
      cycle_count <= '0;
      ring_index  <= '0;
      gap_total   <= '0;
      full        <= 1'b0;
    end else begin
      phase       <= phase_next;
      prev_time   <= prev_time_next;
      cycle_count <= cycle_count_next;
      ring_index  <= ring_index_next;
      gap_total   <= gap_total_next;
      full        <= full_next;
    end
  end

  // Stage A: error flag; count and total are read from the state registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_err <= step_err;
    end
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_fire) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  // Stage B: average by reciprocal multiply, result register
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(gap_total) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (b_load) begin
      m_tuser          <= a_err;
      m_tdata[15:0]    <= cycle_count;
      m_tdata[31:16]   <= prod[SH +: GAP_W];
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase >= POS_11 && phase <= POS_01)
    else $error("phase position out of range");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    ring_index <= IDX_LAST)
    else $error("ring index beyond last entry");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(full) |-> full)
    else $error("ring fill flag dropped");

  a_err_holds_state: assert property (@(posedge clk) disable iff (rst)
    s_fire && step_err |=> $stable(cycle_count) && $stable(gap_total)
      && $stable(prev_time) && $stable(phase))
    else $error("rejected step changed state");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    a_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while both stages are occupied");

endmodule
